// File: rtl/a2h_pkg.sv
// Shared types, codes and constant tables of the printer-byte to HTML encoder.
// Used by the front end, the job queue, the back end and the top level.
package a2h_pkg;

	localparam logic [7:0] EOL_CODE = 8'd155;
	localparam logic [7:0] PUA_HIGH = 8'hE0;

	localparam logic [1:0] PFX_NONE  = 2'd0;
	localparam logic [1:0] PFX_OPEN  = 2'd1;
	localparam logic [1:0] PFX_CLOSE = 2'd2;

	localparam logic [1:0] KIND_RAW    = 2'd0;
	localparam logic [1:0] KIND_ENTITY = 2'd1;
	localparam logic [1:0] KIND_CRLF   = 2'd2;

	localparam logic [4:0] OPEN_LEN  = 5'd17;
	localparam logic [4:0] CLOSE_LEN = 5'd7;

	typedef struct packed {
		logic [1:0]  prefix;
		logic [1:0]  kind;
		logic [2:0]  ndig;
		logic [15:0] value;
	} job_t;

	function automatic logic [15:0] glyph_rom(input logic [6:0] idx);
		logic [15:0] g;
		case (idx)
			7'd0: g = 16'd9829;    7'd1: g = 16'd9500;    7'd2: g = 16'd9621;
			7'd3: g = 16'd9496;    7'd4: g = 16'd9508;    7'd5: g = 16'd9488;
			7'd6: g = 16'd9585;    7'd7: g = 16'd9586;    7'd8: g = 16'd9698;
			7'd9: g = 16'd9623;    7'd10: g = 16'd9699;   7'd11: g = 16'd9629;
			7'd12: g = 16'd9624;   7'd13: g = 16'd9620;   7'd14: g = 16'd9601;
			7'd15: g = 16'd9622;   7'd16: g = 16'd9827;   7'd17: g = 16'd9484;
			7'd18: g = 16'd9472;   7'd19: g = 16'd9532;   7'd20: g = 16'd11044;
			7'd21: g = 16'd9604;   7'd22: g = 16'd9615;   7'd23: g = 16'd9516;
			7'd24: g = 16'd9524;   7'd25: g = 16'd9612;   7'd26: g = 16'd9492;
			7'd27: g = 16'd8455;   7'd28: g = 16'd8593;   7'd29: g = 16'd8595;
			7'd30: g = 16'd8592;   7'd31: g = 16'd8594;   7'd38: g = 16'd38;
			7'd60: g = 16'd60;     7'd62: g = 16'd62;     7'd96: g = 16'd9830;
			7'd123: g = 16'd9824;  7'd124: g = 16'd9475;  7'd125: g = 16'd8598;
			7'd126: g = 16'd9658;  7'd127: g = 16'd9668;
			default: g = 16'd0;
		endcase
		return g;
	endfunction

	function automatic logic [2:0] hex_digits(input logic [15:0] v);
		logic [2:0] n;
		if (v[15:12] != 4'd0) begin
			n = 3'd4;
		end else if (v[11:8] != 4'd0) begin
			n = 3'd3;
		end else if (v[7:4] != 4'd0) begin
			n = 3'd2;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] ch;
		if (d < 4'd10) begin
			ch = 8'h30 + {4'd0, d};
		end else begin
			ch = 8'h57 + {4'd0, d};
		end
		return ch;
	endfunction

	function automatic logic [7:0] open_text(input logic [4:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0: ch = "<";   5'd1: ch = "s";   5'd2: ch = "p";   5'd3: ch = "a";
			5'd4: ch = "n";   5'd5: ch = " ";   5'd6: ch = "c";   5'd7: ch = "l";
			5'd8: ch = "a";   5'd9: ch = "s";   5'd10: ch = "s";  5'd11: ch = "=";
			5'd12: ch = 8'h22; 5'd13: ch = "i"; 5'd14: ch = "v";  5'd15: ch = 8'h22;
			5'd16: ch = ">";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] close_text(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = "<";   3'd1: ch = "/";   3'd2: ch = "s";   3'd3: ch = "p";
			3'd4: ch = "a";   3'd5: ch = "n";   3'd6: ch = ">";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/a2h_front.sv
// Front end: accepts input bytes, tracks span and skip state, classifies each
// byte into a job descriptor for the queue. Depends on a2h_pkg.
module a2h_front
	import a2h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       font_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       buffer_end,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job
);

	logic       skip_q;
	logic       inv_q;
	logic       skip_d;
	logic       inv_d;
	logic       has_job;
	logic       accept;
	logic [6:0] low7;
	logic [15:0] glyph;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign low7     = char_code[6:0];
	assign glyph    = glyph_rom(low7);

	always_comb begin
		skip_d        = skip_q;
		inv_d         = inv_q;
		has_job       = 1'b1;
		q_job.prefix  = PFX_NONE;
		q_job.kind    = KIND_RAW;
		q_job.value   = {8'd0, char_code};
		if (skip_q) begin
			has_job = 1'b0;
			if (buffer_end) begin
				skip_d = 1'b0;
			end
		end else if (char_code == EOL_CODE) begin
			q_job.prefix = inv_q ? PFX_CLOSE : PFX_NONE;
			inv_d        = 1'b0;
			q_job.kind   = KIND_CRLF;
			skip_d       = !buffer_end;
		end else if (font_mode) begin
			if (char_code >= 8'd32 && char_code <= 8'd122 && char_code != 8'd96) begin
				if (glyph != 16'd0) begin
					q_job.kind  = KIND_ENTITY;
					q_job.value = glyph;
				end
			end else begin
				q_job.kind  = KIND_ENTITY;
				q_job.value = {PUA_HIGH, char_code};
			end
		end else begin
			if (char_code[7]) begin
				q_job.prefix = inv_q ? PFX_NONE : PFX_OPEN;
				inv_d        = 1'b1;
			end else begin
				q_job.prefix = inv_q ? PFX_CLOSE : PFX_NONE;
				inv_d        = 1'b0;
			end
			if (glyph != 16'd0) begin
				q_job.kind  = KIND_ENTITY;
				q_job.value = glyph;
			end else begin
				q_job.value = {9'd0, low7};
			end
		end
		q_job.ndig = hex_digits(q_job.value);
	end

	assign q_push = accept && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
			inv_q  <= 1'b0;
		end else if (accept) begin
			skip_q <= skip_d;
			inv_q  <= inv_d;
		end
	end

endmodule

// File: rtl/a2h_queue.sv
// Short job queue between front end and back end, built from registers.
// Depends on a2h_pkg for the job descriptor type.
module a2h_queue
	import a2h_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/a2h_back.sv
// Back end: expands the job at the queue head into HTML bytes, one per cycle
// unless the output is stalled, into an output register. Depends on a2h_pkg.
module a2h_back
	import a2h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam logic PH_PRE  = 1'b0;
	localparam logic PH_BODY = 1'b1;

	logic       phase_q;
	logic [4:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       advance;
	logic       in_pre;
	logic       pre_end;
	logic       body_end;
	logic [2:0] j;
	logic [2:0] pos;
	logic [3:0] nib;
	logic [7:0] next_byte;

	assign advance = head_valid && (!valid_q || out_ready);
	assign in_pre  = (phase_q == PH_PRE) && (head_job.prefix != PFX_NONE);
	assign j       = idx_q[2:0];
	assign pos     = 3'(head_job.ndig + 3'd2 - j);

	always_comb begin
		case (pos[1:0])
			2'd0: nib = head_job.value[3:0];
			2'd1: nib = head_job.value[7:4];
			2'd2: nib = head_job.value[11:8];
			default: nib = head_job.value[15:12];
		endcase
	end

	always_comb begin
		pre_end   = 1'b0;
		body_end  = 1'b0;
		next_byte = head_job.value[7:0];
		if (in_pre) begin
			if (head_job.prefix == PFX_OPEN) begin
				next_byte = open_text(idx_q);
				pre_end   = (idx_q == OPEN_LEN - 5'd1);
			end else begin
				next_byte = close_text(idx_q[2:0]);
				pre_end   = (idx_q == CLOSE_LEN - 5'd1);
			end
		end else begin
			case (head_job.kind)
				KIND_CRLF: begin
					next_byte = (j == 3'd0) ? 8'd13 : 8'd10;
					body_end  = (j == 3'd1);
				end
				KIND_ENTITY: begin
					if (j == 3'd0) begin
						next_byte = "&";
					end else if (j == 3'd1) begin
						next_byte = "#";
					end else if (j == 3'd2) begin
						next_byte = "x";
					end else if (j < head_job.ndig + 3'd3) begin
						next_byte = hex_char(nib);
					end else begin
						next_byte = ";";
						body_end  = 1'b1;
					end
				end
				default: begin
					next_byte = head_job.value[7:0];
					body_end  = 1'b1;
				end
			endcase
		end
	end

	assign pop       = advance && !in_pre && body_end;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= next_byte;
			last_q <= !in_pre && body_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (in_pre) begin
					if (pre_end) begin
						phase_q <= PH_BODY;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end else if (body_end) begin
					phase_q <= PH_PRE;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/atascii_to_html_encoder_core.sv
// Top level of the printer-byte to HTML encoder: mode register, front end,
// job queue and back end. Depends on a2h_pkg, a2h_front, a2h_queue, a2h_back.
//
// Input requests arrive on the s_ stream: s_tdata carries one printer byte and
// s_tlast marks the last byte of a print buffer. HTML text leaves on the m_
// stream one byte per transfer, with m_tlast on the final byte caused by an
// input byte. Bytes dropped after an end of line, up to the buffer end, cause
// no output. The APB port holds the font mode bit at address 0.
// The front end takes one request per cycle while the job queue has room.
// The back end emits one byte per cycle while the receiver takes them; a raw
// byte yields 1 output byte, an entity 5 to 8, a span opener plus entity up
// to 25. The first output byte passes through the job queue and then the
// output register before it is presented. A stalled receiver holds the output
// register; the queue then fills and s_tready drops. Reset clears the mode,
// the span and skip state, the queue and the output valid flag.
module atascii_to_html_encoder_core
	import a2h_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] html_byte
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic font_mode_q;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	job_t push_job;
	job_t head_job;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, font_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			font_mode_q <= pwdata[0];
		end
	end

	a2h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.font_mode  (font_mode_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.buffer_end (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	a2h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	a2h_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_job   (head_job),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("Job pushed into a full queue.");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("Job popped from an empty queue.");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> (m_tvalid && m_tlast))
		else $error("Finished job did not end with a final output byte.");

endmodule
